// ----- rtl/core/rcbs_pkg.sv -----
// Package for the reactive compensator bank selector.
// Holds the word types of the item and result channels, the sequencer states
// and fixed widths; no dependencies.
`default_nettype none

package rcbs_pkg;

    localparam int MEAS_W     = 24;
    localparam int RELAY_W    = 8;
    localparam int NUM_REGS   = 8;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef struct packed {
        logic signed [MEAS_W-1:0] measured_q;
        logic [RELAY_W-1:0]       relay_now;
        logic                     auto_mode;
    } t_in;

    typedef struct packed {
        logic [RELAY_W-1:0] relay_next;
        logic               switch_request;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIN,
        ST_THRESH,
        ST_RESID,
        ST_CAND,
        ST_SEARCH,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/rcbs_regs.sv -----
// APB register file holding the reactive power of each compensator.
// Depends on rcbs_pkg for bus widths.
`default_nettype none

module rcbs_regs #(
    parameter int NUM_COMP   = 8,
    parameter int POWER_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rcbs_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [rcbs_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [rcbs_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    output logic [NUM_COMP-1:0][POWER_BITS-1:0]    o_comp
);
    import rcbs_pkg::*;

    localparam int RIW = $clog2(NUM_REGS);

    logic [NUM_COMP-1:0][POWER_BITS-1:0] r_comp;
    logic [RIW-1:0]                      reg_idx;
    logic                                wr_en;

    assign reg_idx = paddr[RIW+1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_comp  = r_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp <= '0;
        end else if (wr_en) begin
            for (int k = 0; k < NUM_COMP; k++) begin
                if (32'(reg_idx) == 32'(k)) begin
                    r_comp[k] <= pwdata[POWER_BITS-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int k = 0; k < NUM_COMP; k++) begin
            if (32'(reg_idx) == 32'(k)) begin
                prdata = APB_DATA_W'(r_comp[k]);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rcbs_engine.sv -----
// Sequencer and shared accumulator that pick the compensator pattern.
// Walks subsets in Gray order, one add per cycle; depends on rcbs_pkg.
`default_nettype none

module rcbs_engine #(
    parameter int NUM_COMP   = 8,
    parameter int POWER_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  rcbs_pkg::t_in                       i_item,
    input  logic [NUM_COMP-1:0][POWER_BITS-1:0] i_comp,
    output logic                                o_busy,
    output logic                                o_done,
    output rcbs_pkg::t_out                      o_result
);
    import rcbs_pkg::*;

    localparam int IW = (NUM_COMP > 1) ? $clog2(NUM_COMP) : 1;
    localparam int SW = ((POWER_BITS > MEAS_W) ? POWER_BITS : MEAS_W) + 5;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_COMP - 1);

    t_state r_state, n_state;

    logic [IW-1:0]         r_idx;
    logic signed [SW-1:0]  r_meas;
    logic [NUM_COMP-1:0]   r_relay;
    logic                  r_auto;
    logic                  r_any;
    logic [POWER_BITS-1:0] r_minabs;
    logic signed [SW-1:0]  r_acc;
    logic signed [SW-1:0]  r_res;
    logic [NUM_COMP-1:0]   r_cand;
    logic [NUM_COMP-1:0]   r_pat;
    logic [NUM_COMP-1:0]   r_cnt;
    logic                  r_av, r_bv;
    logic signed [SW-1:0]  r_ae, r_as, r_bs;
    logic [NUM_COMP-1:0]   r_ap, r_bp;
    logic [SW-1:0]         r_bd;
    logic                  r_have;
    logic [SW-1:0]         r_bestd;
    logic signed [SW-1:0]  r_bests;
    logic [NUM_COMP-1:0]   r_bestp;
    logic                  r_req;

    logic signed [SW-1:0]  cur_c;
    logic [POWER_BITS-1:0] cur_abs;
    logic [SW-1:0]         meas_abs;
    logic [SW-1:0]         thr;
    logic                  no_action;
    logic [NUM_COMP-1:0]   cnt_nxt;
    logic [IW-1:0]         flip_j;
    logic signed [SW-1:0]  flip_c;
    logic signed [SW-1:0]  acc_op;
    logic signed [SW-1:0]  acc_sum;
    logic [NUM_COMP-1:0]   cand_w;
    logic                  a_ok;
    logic                  better;

    always_comb begin
        cur_c    = SW'($signed(i_comp[r_idx]));
        cur_abs  = (cur_c < 0) ? POWER_BITS'(-cur_c) : POWER_BITS'(cur_c);
        meas_abs = (r_meas < 0) ? SW'(-r_meas) : SW'(r_meas);
        thr      = SW'({r_minabs, 1'b0});
        no_action = !r_auto || !r_any || (meas_abs <= thr);

        cnt_nxt = r_cnt + 1'b1;
        flip_j  = '0;
        for (int k = NUM_COMP - 1; k >= 0; k--) begin
            if (cnt_nxt[k]) begin
                flip_j = IW'(k);
            end
        end
        flip_c = SW'($signed(i_comp[flip_j]));

        acc_op = '0;
        if (r_state == ST_RESID) begin
            acc_op = r_relay[r_idx] ? -cur_c : '0;
        end else if (r_state == ST_SEARCH) begin
            acc_op = r_pat[flip_j] ? -flip_c : flip_c;
        end
        acc_sum = r_acc + acc_op;

        for (int k = 0; k < NUM_COMP; k++) begin
            if (r_acc > 0) begin
                cand_w[k] = $signed(i_comp[k]) < 0;
            end else begin
                cand_w[k] = $signed(i_comp[k]) > 0;
            end
        end

        a_ok   = (r_pat & ~r_cand) == '0;
        better = !r_have || (r_bd < r_bestd)
              || ((r_bd == r_bestd) && (r_bs < r_bests))
              || ((r_bd == r_bestd) && (r_bs == r_bests) && (r_bp < r_bestp));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_MIN;
            end
            ST_MIN: begin
                if (r_idx == LAST_IDX) n_state = ST_THRESH;
            end
            ST_THRESH: begin
                n_state = no_action ? ST_DONE : ST_RESID;
            end
            ST_RESID: begin
                if (r_idx == LAST_IDX) n_state = ST_CAND;
            end
            ST_CAND: begin
                n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (r_cnt == '1) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!r_av && !r_bv) n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        o_busy                  = r_state != ST_IDLE;
        o_done                  = r_state == ST_DONE;
        o_result.relay_next     = RELAY_W'(r_bestp);
        o_result.switch_request = r_req;
    end

    // evaluation pipe: A adds residual, B takes magnitude, then compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av   <= 1'b0;
            r_bv   <= 1'b0;
            r_have <= 1'b0;
            r_req  <= 1'b0;
        end else begin
            r_av <= (r_state == ST_SEARCH) && a_ok;
            r_bv <= r_av;
            if (r_state == ST_CAND) begin
                r_have <= 1'b0;
                r_req  <= 1'b1;
            end else if (r_state == ST_THRESH && no_action) begin
                r_req <= 1'b0;
            end else if (r_bv && better) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ae <= r_res + r_acc;
        r_as <= r_acc;
        r_ap <= r_pat;
        r_bd <= (r_ae < 0) ? SW'(-r_ae) : SW'(r_ae);
        r_bs <= r_as;
        r_bp <= r_ap;
        if (r_state == ST_THRESH && no_action) begin
            r_bestp <= '0;
        end else if (r_bv && better) begin
            r_bestd <= r_bd;
            r_bests <= r_bs;
            r_bestp <= r_bp;
        end

        case (r_state)
            ST_IDLE: begin
                r_idx    <= '0;
                r_any    <= 1'b0;
                r_meas   <= SW'(i_item.measured_q);
                r_relay  <= NUM_COMP'(i_item.relay_now);
                r_auto   <= i_item.auto_mode;
            end
            ST_MIN: begin
                if (cur_c != 0 && (!r_any || cur_abs < r_minabs)) begin
                    r_minabs <= cur_abs;
                    r_any    <= 1'b1;
                end
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            ST_THRESH: begin
                r_acc <= r_meas;
                r_idx <= '0;
            end
            ST_RESID: begin
                r_acc <= acc_sum;
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            ST_CAND: begin
                r_res  <= r_acc;
                r_cand <= cand_w;
                r_acc  <= '0;
                r_pat  <= '0;
                r_cnt  <= '0;
            end
            ST_SEARCH: begin
                if (r_cnt != '1) begin
                    r_acc <= acc_sum;
                    r_pat <= r_pat ^ (NUM_COMP'(1) << flip_j);
                    r_cnt <= cnt_nxt;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("engine did not return to idle after a result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not start the sequencer");

    a_no_req_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.switch_request) |-> (o_result.relay_next == '0))
        else $error("pattern nonzero without a switch request");

    a_pattern_in_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.switch_request) |-> ((r_bestp & ~r_cand) == '0))
        else $error("chosen pattern uses a compensator of the wrong sign");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/reactive_comp_bank_selector.sv -----
// Top level of the reactive compensator bank selector.
// Instantiates rcbs_regs and rcbs_engine; depends on rcbs_pkg.
//
// Usage:
//   Items: drive i_item and raise start; the word is taken at a clock edge
//   where start is high and busy is low. busy stays high until the result.
//   Results: o_done pulses for one cycle with o_result (relay_next,
//   switch_request). The receiver cannot stall; the result is gone after
//   that cycle.
//   Configuration: APB writes to comp_power_i at byte address 4*i, only
//   while busy is low. pready is always high; reads return the register.
// Throughput:
//   An item that triggers a search makes the Gray-order walk over all subsets
//   through the single accumulator, one subset per cycle, and then drains the
//   compare pipe. An item that leads to no action goes from the threshold check
//   straight to the result. One item is in flight at a time; the next is taken
//   after the result.
// Reset: synchronous, active low; all compensator registers read zero and
//   the sequencer returns to idle.
`default_nettype none

module reactive_comp_bank_selector #(
    parameter int NUM_COMP   = 8,
    parameter int POWER_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  rcbs_pkg::t_in                   i_item,
    output logic                            o_done,
    output rcbs_pkg::t_out                  o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcbs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rcbs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rcbs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import rcbs_pkg::*;

    logic [NUM_COMP-1:0][POWER_BITS-1:0] comp;

    rcbs_regs #(
        .NUM_COMP   (NUM_COMP),
        .POWER_BITS (POWER_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_comp  (comp)
    );

    rcbs_engine #(
        .NUM_COMP   (NUM_COMP),
        .POWER_BITS (POWER_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_comp   (comp),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ----- verif/reactive_comp_bank_selector_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for reactive_comp_bank_selector: loads compensator banks
// over APB, drives measurement words and checks each chosen relay pattern.
// Depends on rcbs_pkg and the RTL of the block only.

module reactive_comp_bank_selector_test;
    import rcbs_pkg::*;

    localparam int NUM_COMP     = 8;
    localparam int POWER_BITS   = 24;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_WORDS  = 161;
    localparam int MAX_SHOWN    = 100;
    localparam longint MEAS_MAX = 8388607;

    typedef struct {
        int   bank;
        t_in  w;
        bit   typed;
        t_out want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in                   i_item;
    logic                  o_done;
    t_out                  o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic signed [POWER_BITS-1:0] bank_q [NUM_COMP];
    longint min_mag;
    t_out   pattern_q [$];
    t_row   directed_rows [$];
    int     mismatches = 0;
    int     stall_cycles = 0;
    int     burst_left = 0;

    always #10 i_clk = ~i_clk;

    reactive_comp_bank_selector #(
        .NUM_COMP   (NUM_COMP),
        .POWER_BITS (POWER_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    function automatic longint mag_of(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint bank_sum(input logic [NUM_COMP-1:0] sel);
        longint s;
        s = 0;
        for (int i = 0; i < NUM_COMP; i++)
            if (sel[i]) s += bank_q[i];
        return s;
    endfunction

    function automatic t_out pick_pattern(input t_in w);
        longint              meas;
        longint              resid;
        longint              s;
        longint              d;
        longint              best_d;
        longint              best_s;
        logic [NUM_COMP-1:0] cand;
        logic [NUM_COMP-1:0] best;
        logic [NUM_COMP-1:0] sel;
        bit                  have;
        t_out                r;
        r = '0;
        meas = $signed(w.measured_q);
        if (!w.auto_mode || min_mag == 0 || mag_of(meas) <= 2 * min_mag)
            return r;
        resid = meas - bank_sum(w.relay_now[NUM_COMP-1:0]);
        cand = '0;
        for (int i = 0; i < NUM_COMP; i++)
            if ((resid > 0 && bank_q[i] < 0) || (resid <= 0 && bank_q[i] > 0))
                cand[i] = 1'b1;
        have = 1'b0;
        best = '0;
        best_d = 0;
        best_s = 0;
        for (int p = 0; p < (1 << NUM_COMP); p++) begin
            sel = p[NUM_COMP-1:0];
            if ((sel & ~cand) != '0)
                continue;
            s = bank_sum(sel);
            d = mag_of(resid + s);
            if (!have || d < best_d || (d == best_d && s < best_s)) begin
                best   = sel;
                best_d = d;
                best_s = s;
                have   = 1'b1;
            end
        end
        r.relay_next     = best;
        r.switch_request = 1'b1;
        return r;
    endfunction

    function automatic void add_row(input int bank, input int meas, input int relay,
                                    input bit auto_on, input bit typed = 1'b0,
                                    input int want_relay = 0, input bit want_sw = 1'b0);
        t_row row;
        row.bank                    = bank;
        row.w.measured_q            = MEAS_W'(meas);
        row.w.relay_now             = RELAY_W'(relay);
        row.w.auto_mode             = auto_on;
        row.typed                   = typed;
        row.want.relay_next         = RELAY_W'(want_relay);
        row.want.switch_request     = want_sw;
        directed_rows.push_back(row);
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic push_word(input t_in w, input t_out want);
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pattern_q.push_back(want);
    endtask

    task automatic pace_sender();
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            start <= 1'b0;
            if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(20, 300)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic load_bank(input int vals [NUM_COMP]);
        start <= 1'b0;
        while (pattern_q.size() != 0 || busy) @(posedge i_clk);
        repeat (NUM_COMP + 3) @(posedge i_clk);
        for (int i = 0; i < NUM_COMP; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= APB_ADDR_W'(4 * i);
            pwdata  <= APB_DATA_W'(vals[i]);
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            bank_q[i] = POWER_BITS'(vals[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        min_mag = 0;
        for (int i = 0; i < NUM_COMP; i++)
            if (bank_q[i] != 0 && (min_mag == 0 || mag_of(bank_q[i]) < min_mag))
                min_mag = mag_of(bank_q[i]);
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pattern_q.size() == 0) begin
                flag_mismatch("result word with nothing expected");
            end else begin
                want = pattern_q.pop_front();
                if (o_result.relay_next !== want.relay_next)
                    flag_mismatch($sformatf("relay_next %02h, want %02h",
                                            o_result.relay_next, want.relay_next));
                if (o_result.switch_request !== want.switch_request)
                    flag_mismatch($sformatf("switch_request %b, want %b",
                                            o_result.switch_request, want.switch_request));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int     setups [5][NUM_COMP];
        int     vals [NUM_COMP];
        int     cur_bank;
        int     k;
        int     mode;
        longint span;
        longint mag;
        t_in    w;
        t_out   want;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        for (int i = 0; i < NUM_COMP; i++)
            bank_q[i] = '0;
        min_mag = 0;

        setups = '{
            '{0, 0, 0, 0, 0, 0, 0, 0},
            '{-1000, -2000, -4000, -8000, 1000, 2000, 0, 4000},
            '{1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000},
            '{-900, -1100, -500, -500, 100, 0, 0, 0},
            '{1, -8388608, 8388607, -8388608, 8388607, -8388608, 8388607, -1}
        };

        // empty bank after reset: never acts
        add_row(0, 8388607, 8'hFF, 1'b1, 1'b1, 0, 1'b0);
        add_row(0, -8388608, 8'h00, 1'b1, 1'b1, 0, 1'b0);
        add_row(0, 5, 8'hA5, 1'b0, 1'b1, 0, 1'b0);
        // mixed bank: manual, threshold edges, extremes
        add_row(1, 100000, 8'h00, 1'b0, 1'b1, 0, 1'b0);
        add_row(1, 2000, 8'h00, 1'b1, 1'b1, 0, 1'b0);
        add_row(1, -2000, 8'hFF, 1'b1, 1'b1, 0, 1'b0);
        add_row(1, 2001, 8'h00, 1'b1);
        add_row(1, -2001, 8'h00, 1'b1);
        add_row(1, 8388607, 8'h00, 1'b1);
        add_row(1, -8388608, 8'hFF, 1'b1);
        add_row(1, 12000, 8'h0F, 1'b1);
        add_row(1, -5000, 8'hB0, 1'b1);
        // inductive only: positive residual leaves an empty group
        add_row(2, 50000, 8'h00, 1'b1, 1'b1, 0, 1'b1);
        add_row(2, -50000, 8'h00, 1'b1);
        add_row(2, 3000, 8'hFF, 1'b1);
        // ties on distance and on sum
        add_row(3, 250, 8'h00, 1'b1);
        add_row(3, 600, 8'h00, 1'b1);
        add_row(3, -250, 8'h00, 1'b1);
        add_row(3, 1250, 8'h00, 1'b1);
        // full-scale compensators
        add_row(4, 8388607, 8'h00, 1'b1);
        add_row(4, -8388608, 8'hFF, 1'b1);
        add_row(4, 3, 8'h81, 1'b1);
        add_row(4, 2, 8'h00, 1'b1, 1'b1, 0, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_bank = 0;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].bank != cur_bank) begin
                cur_bank = directed_rows[r].bank;
                load_bank(setups[cur_bank]);
            end
            w    = directed_rows[r].w;
            want = directed_rows[r].typed ? directed_rows[r].want : pick_pattern(w);
            push_word(w, want);
            pace_sender();
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            k = $urandom_range(3, 23);
            for (int i = 0; i < NUM_COMP; i++) begin
                case ($urandom_range(0, 9))
                    0: vals[i] = 0;
                    1: vals[i] = $urandom_range(0, 1) ? 8388607 : -8388608;
                    default: begin
                        mag = $urandom_range(1, (1 << k) - 1);
                        vals[i] = $urandom_range(0, 1) ? -int'(mag) : int'(mag);
                    end
                endcase
            end
            load_bank(vals);
            span = (k >= 20) ? MEAS_MAX : (longint'(1) << (k + 3)) - 1;
            repeat (PHASE_WORDS) begin
                mode = $urandom_range(0, 15);
                if (mode == 2 && min_mag != 0 && 2 * min_mag < MEAS_MAX)
                    mag = 2 * min_mag + $urandom_range(0, 1);
                else
                    mag = $urandom_range(0, int'(span));
                w.measured_q = MEAS_W'($urandom_range(0, 1) ? -mag : mag);
                if (mode == 0)
                    w.measured_q = MEAS_W'($urandom);
                if (mode == 1)
                    w.measured_q = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                w.relay_now = RELAY_W'($urandom_range(0, 255));
                w.auto_mode = ($urandom_range(0, 7) != 0);
                push_word(w, pick_pattern(w));
                pace_sender();
            end
        end

        start <= 1'b0;
        while (pattern_q.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/rcbs_pkg.sv
rtl/core/rcbs_regs.sv
rtl/core/rcbs_engine.sv
rtl/core/reactive_comp_bank_selector.sv
verif/reactive_comp_bank_selector_test.sv
